/* src/owsbr_pkg.sv */
// package: shared types and constants of the 1-wire slave byte receiver
package owsbr_pkg;

    localparam int TICK_W = 20;
    localparam int DLY_W  = 6;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [TICK_W-1:0] TIMEOUT_RST = 20'd1000;
    localparam logic [DLY_W-1:0]  SAMPLE_RST  = 6'd10;
    localparam logic [DLY_W-1:0]  GUARD_RST   = 6'd3;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_SAMPLE  = 2'd1,
        REG_GUARD   = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_WAIT_FALL = 2'd0,
        PH_DELAY     = 2'd1,
        PH_WAIT_RISE = 2'd2,
        PH_GUARD     = 2'd3
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
        logic [DLY_W-1:0]  sample_delay_ticks;
        logic [DLY_W-1:0]  guard_ticks;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              timed_out;
    } t_result;

endpackage

/* src/owsbr_if.sv */
// interfaces: line sample channel and received byte channel
interface owsbr_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source(output valid, output line_level, input ready);
    modport sink(input valid, input line_level, output ready);
endinterface

interface owsbr_out_if;
    logic                        valid;
    logic                        ready;
    logic [owsbr_pkg::BYTE_W-1:0] data_byte;
    logic                        timed_out;

    modport source(output valid, output data_byte, output timed_out, input ready);
    modport sink(input valid, input data_byte, input timed_out, output ready);
endinterface

/* src/owsbr_cfg.sv */
// configuration registers behind the apb-style port
module owsbr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owsbr_pkg::ADDR_W-1:0]  paddr,
    input  logic [owsbr_pkg::DATA_W-1:0]  pwdata,
    output logic [owsbr_pkg::DATA_W-1:0]  o_prdata,
    output owsbr_pkg::t_cfg               o_cfg
);

    owsbr_pkg::t_cfg      r_cfg;
    owsbr_pkg::t_reg_idx  w_idx;
    logic                 w_wr;

    assign w_idx = owsbr_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks      <= owsbr_pkg::TIMEOUT_RST;
            r_cfg.sample_delay_ticks <= owsbr_pkg::SAMPLE_RST;
            r_cfg.guard_ticks        <= owsbr_pkg::GUARD_RST;
        end else if (w_wr) begin
            case (w_idx)
                owsbr_pkg::REG_TIMEOUT: begin
                    r_cfg.timeout_ticks <= pwdata[owsbr_pkg::TICK_W-1:0];
                end
                owsbr_pkg::REG_SAMPLE: begin
                    r_cfg.sample_delay_ticks <= pwdata[owsbr_pkg::DLY_W-1:0];
                end
                owsbr_pkg::REG_GUARD: begin
                    r_cfg.guard_ticks <= pwdata[owsbr_pkg::DLY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        case (w_idx)
            owsbr_pkg::REG_TIMEOUT: begin
                o_prdata = owsbr_pkg::DATA_W'(r_cfg.timeout_ticks);
            end
            owsbr_pkg::REG_SAMPLE: begin
                o_prdata = owsbr_pkg::DATA_W'(r_cfg.sample_delay_ticks);
            end
            owsbr_pkg::REG_GUARD: begin
                o_prdata = owsbr_pkg::DATA_W'(r_cfg.guard_ticks);
            end
            default: begin
                o_prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* src/owsbr_core.sv */
// bit timing state machine, tick counter and byte assembly
module owsbr_core #(
    parameter int DATA_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_line,
    input  owsbr_pkg::t_cfg     i_cfg,
    output owsbr_pkg::t_result  o_res
);

    localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

    owsbr_pkg::t_phase                r_phase, n_phase;
    logic [owsbr_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic [IDX_W-1:0]                 r_bit_idx, n_bit_idx;
    logic [owsbr_pkg::BYTE_W-1:0]     r_shift, n_shift;
    logic                             r_sampled, n_sampled;

    logic [owsbr_pkg::TICK_W-1:0]     w_tick_inc;
    logic                             w_tick_out;
    logic                             w_delay_done;
    logic                             w_guard_done;
    logic                             w_last_bit;
    logic [owsbr_pkg::BYTE_W-1:0]     w_shift_fin;

    assign w_tick_inc   = r_tick + owsbr_pkg::TICK_W'(1);
    assign w_tick_out   = (r_tick >= i_cfg.timeout_ticks);
    assign w_delay_done = (w_tick_inc >= owsbr_pkg::TICK_W'(i_cfg.sample_delay_ticks));
    assign w_guard_done = (w_tick_inc >= owsbr_pkg::TICK_W'(i_cfg.guard_ticks));
    assign w_last_bit   = (r_bit_idx == LAST_IDX);

    // bits beyond the byte are dropped
    always_comb begin
        w_shift_fin = r_shift;
        if (32'(r_bit_idx) < owsbr_pkg::BYTE_W) begin
            w_shift_fin = r_shift | (owsbr_pkg::BYTE_W'(r_sampled) << r_bit_idx);
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            owsbr_pkg::PH_WAIT_FALL: begin
                if (!i_line) begin
                    n_phase = owsbr_pkg::PH_DELAY;
                end
            end
            owsbr_pkg::PH_DELAY: begin
                if (w_delay_done) begin
                    n_phase = owsbr_pkg::PH_WAIT_RISE;
                end
            end
            owsbr_pkg::PH_WAIT_RISE: begin
                priority if (i_line && (i_cfg.guard_ticks != '0)) begin
                    n_phase = owsbr_pkg::PH_GUARD;
                end else if (i_line || w_tick_out) begin
                    n_phase = owsbr_pkg::PH_WAIT_FALL;
                end else begin
                    n_phase = r_phase;
                end
            end
            owsbr_pkg::PH_GUARD: begin
                if (w_guard_done) begin
                    n_phase = owsbr_pkg::PH_WAIT_FALL;
                end
            end
            default: begin
                n_phase = owsbr_pkg::PH_WAIT_FALL;
            end
        endcase
    end

    // counter, assembly and result
    always_comb begin
        logic w_finish;
        logic w_abort;

        w_finish  = 1'b0;
        w_abort   = 1'b0;
        n_tick    = w_tick_inc;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_sampled = r_sampled;
        o_res     = '0;

        unique case (r_phase)
            owsbr_pkg::PH_WAIT_FALL: begin
                priority if (!i_line) begin
                    n_tick = '0;
                end else if (w_tick_out) begin
                    w_abort = 1'b1;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            owsbr_pkg::PH_DELAY: begin
                if (w_delay_done) begin
                    n_sampled = i_line;
                    n_tick    = '0;
                end
            end
            owsbr_pkg::PH_WAIT_RISE: begin
                priority if (i_line && (i_cfg.guard_ticks == '0)) begin
                    w_finish = 1'b1;
                end else if (i_line) begin
                    n_tick = '0;
                end else if (w_tick_out) begin
                    w_abort = 1'b1;
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            owsbr_pkg::PH_GUARD: begin
                if (w_guard_done) begin
                    w_finish = 1'b1;
                end
            end
            default: begin
                n_tick = '0;
            end
        endcase

        if (w_finish) begin
            n_tick = '0;
            if (w_last_bit) begin
                o_res.valid     = 1'b1;
                o_res.data_byte = w_shift_fin;
                n_bit_idx       = '0;
                n_shift         = '0;
            end else begin
                n_bit_idx = r_bit_idx + IDX_W'(1);
                n_shift   = w_shift_fin;
            end
        end

        if (w_abort) begin
            o_res.valid     = 1'b1;
            o_res.timed_out = 1'b1;
            n_tick          = '0;
            n_bit_idx       = '0;
            n_shift         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= owsbr_pkg::PH_WAIT_FALL;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_sampled <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_sampled <= n_sampled;
        end
    end

endmodule

/* src/one_wire_slave_byte_receiver.sv */
// top level: 1-wire slave write slot receiver, one line sample per beat
//
//   channel   dir  payload                     beats
//   i_in      in   line_level (1 bit)          one per microsecond tick
//   o_out     out  data_byte (8), timed_out    zero or one per input beat
//   apb       in   timeout, sample delay, guard registers at 0x0, 0x4, 0x8
//
// each accepted beat lands in the input register; once the result slot is free,
// the bit state machine updates on it and any result lands in the output
// register at the same edge
// one beat per cycle is sustained while o_out is ready; the next state is combinational
// reset loads register defaults and restarts at bit 0 waiting for an edge
// a stalled output holds its beat; the input register still takes a beat until it is
// also full, then ready drops
module one_wire_slave_byte_receiver #(
    parameter int DATA_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    owsbr_in_if.sink                      i_in,
    owsbr_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owsbr_pkg::ADDR_W-1:0]  paddr,
    input  logic [owsbr_pkg::DATA_W-1:0]  pwdata,
    output logic [owsbr_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    owsbr_pkg::t_cfg     w_cfg;
    owsbr_pkg::t_result  w_res;

    // input register
    logic                r_in_valid;
    logic                r_in_line;

    // output register
    logic                          r_out_valid;
    logic [owsbr_pkg::BYTE_W-1:0]  r_out_byte;
    logic                          r_out_to;

    // the held sample steps the state machine when the result slot is free
    logic w_step;

    assign pready = 1'b1;

    owsbr_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .o_prdata (prdata),
        .o_cfg    (w_cfg)
    );

    owsbr_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_line  (r_in_line),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign w_step     = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_line <= i_in.line_level;
        end
    end

    // a new result replaces a drained one; otherwise a taken beat empties the slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.valid) begin
            r_out_byte <= w_res.data_byte;
            r_out_to   <= w_res.timed_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.data_byte = r_out_byte;
    assign o_out.timed_out = r_out_to;

endmodule

/* bench/tb_top.sv */
// testbench: line sample stimulus, register writes and a tick predictor for received bytes
module tb_top;
    import owsbr_pkg::*;

    localparam int DATA_BITS   = 8;
    localparam int RAND_ITEMS  = 1450;
    localparam int MIN_RESULTS = 60;
    localparam int MAX_PHASES  = 40;
    localparam int PHASE_BEATS = 150;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 400000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // one line sample beat; typed rows carry the result they must cause
    typedef struct packed {
        logic              level;
        logic              typed;
        logic [BYTE_W-1:0] data_val;
        logic              to_val;
    } t_line_beat;

    // directed rows, run with timeout 1, zero sample delay, no guard
    localparam int N_DIRECTED = 31;
    localparam t_line_beat DIRECTED [N_DIRECTED] = '{
        // edge wait runs out
        '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b1, 1'b1, 8'h00, 1'b1},
        // byte a5, lsb first: edge, sample, release per bit
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b0, 8'h00, 1'b0}, '{1'b1, 1'b1, 8'ha5, 1'b0},
        // release wait runs out, then the line still low is taken as an edge
        '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b0, 1'b0, 8'h00, 1'b0}, '{1'b0, 1'b0, 8'h00, 1'b0},
        '{1'b0, 1'b1, 8'h00, 1'b1}, '{1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    owsbr_in_if  in_if ();
    owsbr_out_if out_if ();

    one_wire_slave_byte_receiver #(.DATA_BITS(DATA_BITS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and its copy of the registers
    t_phase            rx_phase;
    logic [31:0]       rx_ticks;
    int                rx_bit;
    logic [BYTE_W-1:0] rx_shift;
    logic              rx_sampled;
    logic [TICK_W-1:0] cfg_timeout;
    logic [DLY_W-1:0]  cfg_sample;
    logic [DLY_W-1:0]  cfg_guard;

    t_line_beat line_beats [$];
    t_result    pending_bytes [$];
    int         beats_queued = 0;
    int         beats_taken  = 0;
    int         results_seen = 0;
    int         fail_count   = 0;
    int         cycle_count  = 0;
    bit         in_burst     = 1'b0;
    bit         out_burst    = 1'b0;
    bit         hold_go      = 1'b0;

    function automatic void restart_rx();
        rx_phase = PH_WAIT_FALL;
        rx_ticks = '0;
        rx_bit   = 0;
        rx_shift = '0;
    endfunction

    function automatic bit finish_bit(output t_result res);
        res = '0;
        // bits past the eighth are dropped
        if (rx_bit < BYTE_W) rx_shift[rx_bit] = rx_shift[rx_bit] | rx_sampled;
        rx_phase = PH_WAIT_FALL;
        rx_ticks = '0;
        if (rx_bit + 1 >= DATA_BITS) begin
            res = '{valid: 1'b1, data_byte: rx_shift, timed_out: 1'b0};
            restart_rx();
            return 1'b1;
        end
        rx_bit++;
        return 1'b0;
    endfunction

    function automatic bit abort_byte(output t_result res);
        res = '{valid: 1'b1, data_byte: '0, timed_out: 1'b1};
        restart_rx();
        return 1'b1;
    endfunction

    // one tick of the write slot receiver; returns 1 when a result is due
    function automatic bit decode_tick(input logic level, output t_result res);
        res = '0;
        case (rx_phase)
            PH_WAIT_FALL: begin
                if (!level) begin
                    rx_phase = PH_DELAY;
                    rx_ticks = '0;
                end else if (rx_ticks >= 32'(cfg_timeout)) begin
                    return abort_byte(res);
                end else begin
                    rx_ticks++;
                end
            end
            PH_DELAY: begin
                // a zero delay acts as one
                rx_ticks++;
                if (rx_ticks >= 32'(cfg_sample)) begin
                    rx_sampled = level;
                    rx_phase   = PH_WAIT_RISE;
                    rx_ticks   = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (level) begin
                    if (cfg_guard == '0) return finish_bit(res);
                    rx_phase = PH_GUARD;
                    rx_ticks = '0;
                end else if (rx_ticks >= 32'(cfg_timeout)) begin
                    return abort_byte(res);
                end else begin
                    rx_ticks++;
                end
            end
            default: begin
                rx_ticks++;
                if (rx_ticks >= 32'(cfg_guard)) return finish_bit(res);
            end
        endcase
        return 1'b0;
    endfunction

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read every register back against the predictor's copy
    task automatic check_regs();
        logic [DATA_W-1:0] want [3];
        logic [DATA_W-1:0] got;
        want[REG_TIMEOUT] = DATA_W'(cfg_timeout);
        want[REG_SAMPLE]  = DATA_W'(cfg_sample);
        want[REG_GUARD]   = DATA_W'(cfg_guard);
        for (int i = 0; i < 3; i++) begin
            apb_read({i[1:0], 2'b00}, got);
            if (got !== want[i]) begin
                fail_count++;
                $display("%0t: register %0d read expected %h actual %h", $time, i, want[i], got);
            end
        end
    endtask

    // write all three registers with junk above each field, then read back
    task automatic set_config(input logic [TICK_W-1:0] tmo, input logic [DLY_W-1:0] smp,
                              input logic [DLY_W-1:0] grd);
        apb_write({REG_TIMEOUT, 2'b00}, ($urandom() & 32'hfff0_0000) | DATA_W'(tmo));
        apb_write({REG_SAMPLE, 2'b00}, ($urandom() & 32'hffff_ffc0) | DATA_W'(smp));
        apb_write({REG_GUARD, 2'b00}, ($urandom() & 32'hffff_ffc0) | DATA_W'(grd));
        cfg_timeout = tmo;
        cfg_sample  = smp;
        cfg_guard   = grd;
        check_regs();
    endtask

    // every beat sent and every result back, then room for beats still in the pipe
    task automatic wait_idle();
        while (beats_taken != beats_queued || pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_level(input logic level);
        line_beats.push_back('{level: level, typed: 1'b0, data_val: '0, to_val: 1'b0});
        beats_queued++;
    endtask

    // one write slot: short low reads as 1, long low as 0, then high past the guard
    task automatic add_slot(input logic val);
        int dly;
        int lo;
        int hi;
        dly = (cfg_sample == '0) ? 1 : int'(cfg_sample);
        lo  = val ? $urandom_range(dly, 1) : dly + $urandom_range(3, 1);
        hi  = (val ? dly + 1 - lo : 0) + int'(cfg_guard) + $urandom_range(3, 1);
        repeat (lo) push_level(1'b0);
        repeat (hi) push_level(1'b1);
    endtask

    // mostly whole frames, some cut short, some noise and over-long waits
    task automatic fill_phase();
        int                start;
        int                pick;
        int                nbits;
        logic [BYTE_W-1:0] val;
        logic              lvl;
        start = beats_queued;
        while (beats_queued - start < PHASE_BEATS) begin
            pick = $urandom_range(9, 0);
            if (pick < 8) begin
                val   = BYTE_W'($urandom());
                nbits = ($urandom_range(9, 0) == 0) ? $urandom_range(7, 1) : DATA_BITS;
                for (int i = 0; i < nbits; i++) add_slot(val[i % BYTE_W]);
            end else if (pick == 8 || cfg_timeout > 64) begin
                repeat ($urandom_range(16, 1)) push_level(1'($urandom()));
            end else begin
                lvl = 1'($urandom());
                repeat (int'(cfg_timeout) + $urandom_range(3, 1)) push_level(lvl);
            end
        end
    endtask

    // sender: random gaps per beat, valid held high across back to back beats
    initial begin
        t_line_beat cur;
        t_result    res;
        bit         due;
        int         gap;
        in_if.valid      = 1'b0;
        in_if.line_level = 1'b0;
        gap = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (line_beats.size() == 0 || gap > 0) begin
                in_if.valid <= 1'b0;
                if (gap > 0) gap--;
                @(negedge i_clk);
            end else begin
                cur = line_beats.pop_front();
                in_if.valid      <= 1'b1;
                in_if.line_level <= cur.level;
                @(posedge i_clk);
                while (!in_if.ready) @(posedge i_clk);
                due = decode_tick(cur.level, res);
                if (cur.typed)
                    pending_bytes.push_back('{valid: 1'b1, data_byte: cur.data_val,
                                              timed_out: cur.to_val});
                else if (due)
                    pending_bytes.push_back(res);
                beats_taken++;
                gap = in_burst ? 0 : $urandom_range(3, 0);
                @(negedge i_clk);
            end
        end
    end

    // receiver: random stall per beat, one long hold-off while beats keep coming
    initial begin
        int wait_cycles;
        bit held;
        out_if.ready = 1'b0;
        held = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = out_burst ? 0 : $urandom_range(3, 0);
            if (hold_go && !held) begin
                held        = 1'b1;
                wait_cycles = HOLD_CYCLES;
            end
            if (wait_cycles > 0) begin
                out_if.ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_bytes.size() == 0) begin
                fail_count++;
                $display("%0t: beat with nothing expected, actual data_byte %h timed_out %b",
                         $time, out_if.data_byte, out_if.timed_out);
            end else begin
                want = pending_bytes.pop_front();
                if (out_if.data_byte !== want.data_byte) begin
                    fail_count++;
                    $display("%0t: data_byte expected %h actual %h",
                             $time, want.data_byte, out_if.data_byte);
                end
                if (out_if.timed_out !== want.timed_out) begin
                    fail_count++;
                    $display("%0t: timed_out expected %b actual %b",
                             $time, want.timed_out, out_if.timed_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("FAIL one_wire_slave_byte_receiver");
            $finish;
        end
    end

    initial begin
        int ph;
        cfg_timeout = TIMEOUT_RST;
        cfg_sample  = SAMPLE_RST;
        cfg_guard   = GUARD_RST;
        rx_sampled  = 1'b0;
        restart_rx();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, then an unmapped register write that must change nothing
        check_regs();
        apb_write({REG_UNUSED, 2'b00}, 32'hffff_ffff);
        check_regs();

        set_config(20'd1, 6'd0, 6'd0);
        for (int i = 0; i < N_DIRECTED; i++) begin
            line_beats.push_back(DIRECTED[i]);
            beats_queued++;
        end
        wait_idle();

        // random phases, extremes of the registers first
        ph = 0;
        while ((beats_queued < RAND_ITEMS + N_DIRECTED || results_seen < MIN_RESULTS)
               && ph < MAX_PHASES) begin
            case (ph)
                0:       set_config(20'd0, 6'd0, 6'd0);
                1:       set_config(20'hfffff, 6'd63, 6'd63);
                2:       set_config(20'd1, 6'd1, 6'd0);
                3:       set_config(TIMEOUT_RST, SAMPLE_RST, GUARD_RST);
                default: set_config(
                    ($urandom_range(4, 0) == 0) ? TICK_W'($urandom()) :
                                                  TICK_W'($urandom_range(40, 0)),
                    ($urandom_range(7, 0) == 0) ? DLY_W'($urandom()) :
                                                  DLY_W'($urandom_range(6, 0)),
                    ($urandom_range(7, 0) == 0) ? DLY_W'($urandom()) :
                                                  DLY_W'($urandom_range(5, 0)));
            endcase
            in_burst  = ($urandom_range(3, 0) == 0);
            out_burst = ($urandom_range(3, 0) == 0);
            fill_phase();
            // zero timeout gives a result on nearly every beat, so the block backs up
            if (ph == 0) hold_go = 1'b1;
            wait_idle();
            ph++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS one_wire_slave_byte_receiver");
        else
            $display("FAIL one_wire_slave_byte_receiver");
        $finish;
    end

endmodule
